>>> rtl/ats_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register codes for the address-to-symbol lookup.
// Used by every module of the block; depends on nothing else.
package ats_pkg;

    // Fixed field widths.
    localparam int ADDR_W    = 64;
    localparam int SYM_IDX_W = 12;
    localparam int COUNT_W   = 13;
    localparam int CFG_IDX_W = 4;
    // Wide enough to hold any table index or count up to 65536.
    localparam int IDX_EXT_W = 17;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_SYMBOLS      = 4096;
    localparam int DEF_INCLUDE_ALL_DATA = 0;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_START       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_END         = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_TEXT_START  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_TEXT_END    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_TEXT_START = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_TEXT_END   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_END        = 4'd7;

    // Request actions.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Command kinds passed from front to back.
    typedef logic [1:0] cmd_kind_t;
    localparam cmd_kind_t CMD_SKIP   = 2'd0; // answer with an empty word only
    localparam cmd_kind_t CMD_LOAD   = 2'd1; // write one table entry
    localparam cmd_kind_t CMD_LOOKUP = 2'd2; // run the search

    typedef struct packed {
        logic              action;
        logic [SYM_IDX_W-1:0] entry_index;
        logic [ADDR_W-1:0] entry_address;
        logic [ADDR_W-1:0] query_address;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [SYM_IDX_W-1:0] symbol_index;
        logic [ADDR_W-1:0] symbol_size;
        logic [ADDR_W-1:0] symbol_offset;
    } rsp_t;

    // One classified command: value is the entry address for a load and the
    // query address for a lookup.
    typedef struct packed {
        cmd_kind_t            kind;
        logic [SYM_IDX_W-1:0] entry_index;
        logic [ADDR_W-1:0]    value;
        logic [ADDR_W-1:0]    section_end;
    } cmd_t;

endpackage

>>> rtl/ats_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, request acceptance and classification.
// Depends on ats_pkg.
module ats_front
    import ats_pkg::*;
#(
    parameter int MAX_SYMBOLS      = DEF_MAX_SYMBOLS,
    parameter int INCLUDE_ALL_DATA = DEF_INCLUDE_ALL_DATA,
    localparam int CW = $clog2(MAX_SYMBOLS + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output cmd_t                 cmd,
    output logic [CW-1:0]        count
);

    logic [COUNT_W-1:0] symbol_count_reg;
    logic [ADDR_W-1:0]  text_start_reg;
    logic [ADDR_W-1:0]  text_end_reg;
    logic [ADDR_W-1:0]  init_text_start_reg;
    logic [ADDR_W-1:0]  init_text_end_reg;
    logic [ADDR_W-1:0]  extra_text_start_reg;
    logic [ADDR_W-1:0]  extra_text_end_reg;
    logic [ADDR_W-1:0]  image_end_reg;

    logic in_text;
    logic in_init;
    logic in_extra;
    logic in_image;
    logic accepted;
    logic index_ok;

    assign cfg_ready = 1'b1;

    // Configuration register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_count_reg     <= '0;
            text_start_reg       <= '0;
            text_end_reg         <= '0;
            init_text_start_reg  <= '0;
            init_text_end_reg    <= '0;
            extra_text_start_reg <= '0;
            extra_text_end_reg   <= '0;
            image_end_reg        <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SYMBOL_COUNT:     symbol_count_reg     <= cfg_data[COUNT_W-1:0];
                REG_TEXT_START:       text_start_reg       <= cfg_data;
                REG_TEXT_END:         text_end_reg         <= cfg_data;
                REG_INIT_TEXT_START:  init_text_start_reg  <= cfg_data;
                REG_INIT_TEXT_END:    init_text_end_reg    <= cfg_data;
                REG_EXTRA_TEXT_START: extra_text_start_reg <= cfg_data;
                REG_EXTRA_TEXT_END:   extra_text_end_reg   <= cfg_data;
                REG_IMAGE_END:        image_end_reg        <= cfg_data;
                default:              ;
            endcase
        end
    end

    // The count saturates at the table size.
    always_comb
    begin
        if (IDX_EXT_W'(symbol_count_reg) > IDX_EXT_W'(MAX_SYMBOLS))
            count = CW'(MAX_SYMBOLS);
        else
            count = CW'(symbol_count_reg);
    end

    // Section range checks on the query address.
    always_comb
    begin
        in_text  = (req.query_address >= text_start_reg) &&
                   (req.query_address <= text_end_reg);
        in_init  = (req.query_address >= init_text_start_reg) &&
                   (req.query_address <= init_text_end_reg);
        in_extra = (req.query_address >= extra_text_start_reg) &&
                   (req.query_address <= extra_text_end_reg);
        in_image = (req.query_address >= text_start_reg) &&
                   (req.query_address <= image_end_reg);
        if (INCLUDE_ALL_DATA != 0)
            accepted = in_image;
        else
            accepted = in_text || in_init || in_extra;
        index_ok = IDX_EXT_W'(req.entry_index) < IDX_EXT_W'(MAX_SYMBOLS);
    end

    // Classify the word and hand it to the queue.
    always_comb
    begin
        cmd.entry_index = req.entry_index;
        if (req.action == ACT_LOAD)
        begin
            cmd.kind  = index_ok ? CMD_LOAD : CMD_SKIP;
            cmd.value = req.entry_address;
        end
        else
        begin
            cmd.kind  = (accepted && (count != '0)) ? CMD_LOOKUP : CMD_SKIP;
            cmd.value = req.query_address;
        end
        if (in_init)
            cmd.section_end = init_text_end_reg;
        else if (INCLUDE_ALL_DATA != 0)
            cmd.section_end = image_end_reg;
        else
            cmd.section_end = text_end_reg;
    end

    assign cmd_valid = req_valid;
    assign req_ready = cmd_ready;

endmodule

>>> rtl/ats_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the search engine.
// Depends on ats_pkg.
module ats_fifo
    import ats_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int FW = $clog2(Q_DEPTH + 1);

    cmd_t          slot_reg [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = fill_reg != FW'(Q_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> rtl/ats_back.sv
`timescale 1ns / 1ps
// Back end: address table memory, search sequencer and result register.
// Depends on ats_pkg.
module ats_back
    import ats_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
    localparam int CW = $clog2(MAX_SYMBOLS + 1),
    localparam int IW = $clog2(MAX_SYMBOLS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  cmd_t          cmd,
    input  logic [CW-1:0] count,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rsp_t          rsp
);

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_SEARCH     = 4'd1;
    localparam logic [3:0] ST_CMP        = 4'd2;
    localparam logic [3:0] ST_START_WAIT = 4'd3;
    localparam logic [3:0] ST_ALIAS_RD   = 4'd4;
    localparam logic [3:0] ST_ALIAS_CMP  = 4'd5;
    localparam logic [3:0] ST_NEXT_RD    = 4'd6;
    localparam logic [3:0] ST_NEXT_CMP   = 4'd7;
    localparam logic [3:0] ST_FIN        = 4'd8;

    logic [ADDR_W-1:0] mem [MAX_SYMBOLS];
    logic [ADDR_W-1:0] rd_data_reg;
    logic [IW-1:0]     rd_addr;
    logic              rd_en;
    logic [IW-1:0]     wr_addr;
    logic              mem_we;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [CW-1:0]     lo_reg;
    logic [CW-1:0]     lo_next;
    logic [CW-1:0]     hi_reg;
    logic [CW-1:0]     hi_next;
    logic [CW-1:0]     mid_reg;
    logic [CW-1:0]     mid_next;
    logic [CW-1:0]     j_reg;
    logic [CW-1:0]     j_next;
    logic [ADDR_W-1:0] q_reg;
    logic [ADDR_W-1:0] q_next;
    logic [ADDR_W-1:0] sec_end_reg;
    logic [ADDR_W-1:0] sec_end_next;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] start_next;
    logic [ADDR_W-1:0] end_reg;
    logic [ADDR_W-1:0] end_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;

    logic [CW:0]            mid_sum;
    logic [CW-1:0]          mid;
    logic [IDX_EXT_W-1:0]   load_idx;
    logic                   do_pop;

    assign cmd_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign do_pop    = cmd_valid && cmd_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[CW:1];
    assign load_idx = IDX_EXT_W'(cmd.entry_index);
    assign wr_addr  = load_idx[IW-1:0];
    assign mem_we   = do_pop && (cmd.kind == CMD_LOAD);

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= cmd.value;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Search sequencer: binary search, alias step-back, then next-greater scan.
    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        j_next         = j_reg;
        q_next         = q_reg;
        sec_end_next   = sec_end_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        rd_en          = 1'b0;
        rd_addr        = lo_reg[IW-1:0];

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (do_pop)
                begin
                    if (cmd.kind == CMD_LOOKUP)
                    begin
                        lo_next      = '0;
                        hi_next      = count;
                        q_next       = cmd.value;
                        sec_end_next = cmd.section_end;
                        state_next   = ST_SEARCH;
                    end
                    else
                    begin
                        // Loads and rejected lookups give an empty word.
                        rsp_next       = '0;
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                rd_en = 1'b1;
                if ((hi_reg - lo_reg) > CW'(1))
                begin
                    rd_addr    = mid[IW-1:0];
                    mid_next   = mid;
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_START_WAIT;
                end
            end
            ST_CMP:
            begin
                if (rd_data_reg <= q_reg)
                    lo_next = mid_reg;
                else
                    hi_next = mid_reg;
                state_next = ST_SEARCH;
            end
            ST_START_WAIT:
            begin
                start_next = rd_data_reg;
                state_next = ST_ALIAS_RD;
            end
            ST_ALIAS_RD:
            begin
                if (lo_reg == '0)
                begin
                    j_next     = lo_reg + 1'b1;
                    state_next = ST_NEXT_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = lo_next[IW-1:0] - 1'b1;
                    state_next = ST_ALIAS_CMP;
                end
            end
            ST_ALIAS_CMP:
            begin
                if (rd_data_reg == start_reg)
                begin
                    lo_next    = lo_reg - 1'b1;
                    state_next = ST_ALIAS_RD;
                end
                else
                begin
                    j_next     = lo_reg + 1'b1;
                    state_next = ST_NEXT_RD;
                end
            end
            ST_NEXT_RD:
            begin
                if (j_reg >= count)
                begin
                    end_next   = sec_end_reg;
                    state_next = ST_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = j_reg[IW-1:0];
                    state_next = ST_NEXT_CMP;
                end
            end
            ST_NEXT_CMP:
            begin
                if (rd_data_reg > start_reg)
                begin
                    end_next   = rd_data_reg;
                    state_next = ST_FIN;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_NEXT_RD;
                end
            end
            ST_FIN:
            begin
                rsp_next.found         = 1'b1;
                rsp_next.symbol_index  = SYM_IDX_W'(lo_reg);
                rsp_next.symbol_size   = end_reg - start_reg;
                rsp_next.symbol_offset = q_reg - start_reg;
                rsp_valid_next         = 1'b1;
                state_next             = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        j_reg       <= j_next;
        q_reg       <= q_next;
        sec_end_reg <= sec_end_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        rsp_reg     <= rsp_next;
    end

    // The search window never collapses while it is being narrowed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (lo_reg < mid_reg) && (mid_reg < hi_reg))
        else $error("search window out of order");

    // A finished lookup always leaves a word in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> rsp_valid_reg && (state_reg == ST_IDLE))
        else $error("lookup finished without a result");

    // The table is written only between lookups.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE) && !rd_en)
        else $error("table write during a search");

    // The forward scan stays inside the loaded entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NEXT_CMP) |-> (j_reg < count))
        else $error("scan beyond the symbol count");

endmodule

>>> rtl/address_to_symbol_lookup_core.sv
`timescale 1ns / 1ps
// Top level of the address-to-symbol lookup block.
// Depends on ats_pkg, ats_front, ats_fifo and ats_back.

// The block resolves an address to the last symbol whose start address is not
// above it, reporting the index of the first alias, the symbol size and the
// offset into it. A load word is written to the table as the back end takes it.
// A lookup runs a binary search over the loaded entries, steps back over
// equal aliases and then scans forward to the next greater start address;
// its length grows with the log of the symbol count, the number of aliases
// stepped over and the number of entries scanned. It is set by the single read
// port of the address table, whose registered data is compared in a state of
// its own after each read. A two-word queue lets new words be accepted while a
// search or an unread result is pending.
module address_to_symbol_lookup_core
    import ats_pkg::*;
#(
    parameter int MAX_SYMBOLS      = DEF_MAX_SYMBOLS,
    parameter int INCLUDE_ALL_DATA = DEF_INCLUDE_ALL_DATA
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output rsp_t                 rsp
);

    localparam int CW = $clog2(MAX_SYMBOLS + 1);

    logic          push_valid;
    logic          push_ready;
    cmd_t          push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    cmd_t          pop_cmd;
    logic [CW-1:0] count;

    // Configuration and classification.
    ats_front #(
        .MAX_SYMBOLS      (MAX_SYMBOLS),
        .INCLUDE_ALL_DATA (INCLUDE_ALL_DATA)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (push_valid),
        .cmd_ready (push_ready),
        .cmd       (push_cmd),
        .count     (count)
    );

    // Decoupling queue.
    ats_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Table and search engine.
    ats_back #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_cmd),
        .count     (count),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
